// ----- hdl/mp4_box_span_finder_top_macros.svh -----
// Assertion helpers shared by the box span finder RTL.
// Each macro wraps a clocked property with a synchronous reset disable.
`ifndef MP4_BOX_SPAN_FINDER_TOP_MACROS_SVH
`define MP4_BOX_SPAN_FINDER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define MBSF_ASSERT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define MBSF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MBSF_ASSERT(lbl, clk, rst, ante, cons, msg)
`define MBSF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hdl/mbsf_pkg.sv -----
package mbsf_pkg;

   // File offsets wrap at this width
   localparam int OFFSET_BITS = 32;
   typedef logic [OFFSET_BITS-1:0] ofs_type;

   // Box header geometry
   localparam int HDR_BYTES = 8;
   localparam int FILL_BITS = $clog2(HDR_BYTES);
   localparam int HDR_LAST  = HDR_BYTES - 1;
   typedef logic [FILL_BITS-1:0] fill_type;

   // Box type codes, big-endian four characters
   localparam logic [31:0] FOURCC_FTYP = 32'h6674_7970;
   localparam logic [31:0] FOURCC_MOOV = 32'h6d6f_6f76;
   localparam logic [31:0] FOURCC_FREE = 32'h6672_6565;
   localparam logic [31:0] FOURCC_WIDE = 32'h7769_6465;
   localparam logic [31:0] FOURCC_META = 32'h6d65_7461;
   localparam logic [31:0] FOURCC_MDAT = 32'h6d64_6174;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOT_MP4  = 2'd1,
      ST_BAD_SIZE = 2'd2
   } status_type;

   // Walk state snapshot taken at the final byte of a file
   typedef struct packed {
      ofs_type     total;
      logic [31:0] leading_sum;
      logic        leading_ok;
      ofs_type     mdat_end;
      logic        walk_failed;
      logic        not_mp4;
   } span_type;

   function automatic logic is_magic_type(logic [31:0] t);
      return (t == FOURCC_FTYP) || (t == FOURCC_MOOV);
   endfunction

   function automatic logic is_leading_type(logic [31:0] t);
      return (t == FOURCC_FTYP) || (t == FOURCC_MOOV) || (t == FOURCC_FREE) ||
             (t == FOURCC_WIDE) || (t == FOURCC_META);
   endfunction

   // Zero-extend or truncate an offset to 32 bits
   function automatic logic [31:0] to_u32(ofs_type v);
      logic [63:0] w;
      w = 64'(v);
      return w[31:0];
   endfunction

endpackage

// ----- hdl/mbsf_ifs.sv -----
// Byte stream into the box walker
interface mbsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Span results out of the box walker
interface mbsf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] header_length;
   logic [31:0] trailer_length;
   logic [31:0] payload_length;
   logic [1:0]  status;

   modport source (output valid, output header_length, output trailer_length,
                   output payload_length, output status, input ready);
   modport sink   (input valid, input header_length, input trailer_length,
                   input payload_length, input status, output ready);
endinterface

// ----- hdl/mbsf_walker.sv -----
module mbsf_walker (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         data_byte,
   input  logic               last_byte,
   output mbsf_pkg::span_type span
);

   mbsf_pkg::ofs_type  offset_ff, offset_in;
   logic [63:0]        hdr_ff, hdr_in;
   mbsf_pkg::fill_type fill_ff, fill_in;
   logic [31:0]        skip_ff, skip_in;
   logic               in_run_ff, in_run_in;
   logic [31:0]        lead_sum_ff, lead_sum_in;
   logic               lead_fail_ff, lead_fail_in;
   mbsf_pkg::ofs_type  mdat_end_ff, mdat_end_in;
   logic               walk_fail_ff, walk_fail_in;
   logic               magic_bad_ff, magic_bad_in;
   logic               first_done_ff, first_done_in;

   logic               active;
   logic               take;
   logic               proceed;
   logic [63:0]        shifted;
   logic [31:0]        box_size;
   logic [31:0]        box_type;
   logic               size_bad;

   // Work out the walk state after this byte
   always_comb begin
      offset_in     = offset_ff + mbsf_pkg::ofs_type'(1);
      hdr_in        = hdr_ff;
      fill_in       = fill_ff;
      skip_in       = skip_ff;
      in_run_in     = in_run_ff;
      lead_sum_in   = lead_sum_ff;
      lead_fail_in  = lead_fail_ff;
      mdat_end_in   = mdat_end_ff;
      walk_fail_in  = walk_fail_ff;
      magic_bad_in  = magic_bad_ff;
      first_done_in = first_done_ff;

      active   = !walk_fail_ff && !magic_bad_ff;
      shifted  = {hdr_ff[55:0], data_byte};
      box_size = shifted[63:32];
      box_type = shifted[31:0];
      size_bad = box_size <= 32'(mbsf_pkg::HDR_BYTES);
      take     = active && (skip_ff == '0) &&
                 (fill_ff == mbsf_pkg::fill_type'(mbsf_pkg::HDR_LAST));
      proceed  = take && (first_done_ff || mbsf_pkg::is_magic_type(box_type));

      // Skip a box body, or shift in a header byte
      if (active) begin
         if (skip_ff != '0) begin
            skip_in = skip_ff - 32'd1;
         end else begin
            hdr_in  = shifted;
            fill_in = fill_ff + mbsf_pkg::fill_type'(1);
         end
      end

      // First header must carry the file magic
      if (take && !first_done_ff) begin
         first_done_in = 1'b1;
         if (!mbsf_pkg::is_magic_type(box_type)) begin
            magic_bad_in = 1'b1;
         end
      end

      if (proceed) begin
         // Accumulate the leading metadata run
         if (in_run_ff) begin
            if (mbsf_pkg::is_leading_type(box_type)) begin
               if (size_bad) begin
                  lead_fail_in = 1'b1;
               end else begin
                  lead_sum_in = lead_sum_ff + box_size;
               end
            end else begin
               in_run_in = 1'b0;
            end
         end
         // Box end is header start plus size
         if (box_type == mbsf_pkg::FOURCC_MDAT) begin
            mdat_end_in = offset_ff + mbsf_pkg::ofs_type'(box_size) -
                          mbsf_pkg::ofs_type'(mbsf_pkg::HDR_LAST);
         end
         if (size_bad) begin
            walk_fail_in = 1'b1;
         end else begin
            skip_in = box_size - 32'(mbsf_pkg::HDR_BYTES);
         end
      end
   end

   // Hand the post-byte state to the result stage
   always_comb begin
      span.total       = offset_in;
      span.leading_sum = lead_sum_in;
      span.leading_ok  = !lead_fail_in && !in_run_in;
      span.mdat_end    = mdat_end_in;
      span.walk_failed = walk_fail_in;
      span.not_mp4     = !first_done_in || magic_bad_in;
   end

   // Advance per byte; start afresh after the final byte
   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         offset_ff     <= '0;
         hdr_ff        <= '0;
         fill_ff       <= '0;
         skip_ff       <= '0;
         in_run_ff     <= 1'b1;
         lead_sum_ff   <= '0;
         lead_fail_ff  <= 1'b0;
         mdat_end_ff   <= '0;
         walk_fail_ff  <= 1'b0;
         magic_bad_ff  <= 1'b0;
         first_done_ff <= 1'b0;
      end else if (step) begin
         offset_ff     <= offset_in;
         hdr_ff        <= hdr_in;
         fill_ff       <= fill_in;
         skip_ff       <= skip_in;
         in_run_ff     <= in_run_in;
         lead_sum_ff   <= lead_sum_in;
         lead_fail_ff  <= lead_fail_in;
         mdat_end_ff   <= mdat_end_in;
         walk_fail_ff  <= walk_fail_in;
         magic_bad_ff  <= magic_bad_in;
         first_done_ff <= first_done_in;
      end
   end

endmodule

// ----- hdl/mp4_box_span_finder_top.sv -----
// A result passes from the snapshot register to the result register on rsp.
// Throughput: one byte per cycle unless a final byte waits, as set out below.
// A final byte waits only while two earlier results are held, one in the
// snapshot register and one on rsp still waiting for its transfer.
// Reset: synchronous, active high; clears the walk state and all valid flags.
// Each result also returns the walk state to its reset value for the next file.
`include "mp4_box_span_finder_top_macros.svh"

module mp4_box_span_finder_top (
   input  logic        clock,
   input  logic        reset,
   mbsf_req_if.sink    req_ch,
   mbsf_rsp_if.source  rsp_ch
);

   // Input register
   logic       a_valid_ff;
   logic [7:0] a_byte_ff;
   logic       a_last_ff;

   // Snapshot of the walk at the final byte
   logic               s_valid_ff, s_valid_in;
   mbsf_pkg::span_type s_span_ff;
   mbsf_pkg::span_type span;

   // Result register
   logic                 o_valid_ff;
   logic [31:0]          o_hdr_ff, o_hdr_in;
   logic [31:0]          o_trl_ff, o_trl_in;
   logic [31:0]          o_pay_ff, o_pay_in;
   mbsf_pkg::status_type o_status_ff, o_status_in;

   logic a_step;
   logic s_move;

   assign s_move       = s_valid_ff && (!o_valid_ff || rsp_ch.ready);
   assign a_step       = a_valid_ff && (!a_last_ff || !s_valid_ff || s_move);
   assign req_ch.ready = !a_valid_ff || a_step;
   assign s_valid_in   = (s_valid_ff && !s_move) || (a_step && a_last_ff);

   mbsf_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .step      (a_step),
      .data_byte (a_byte_ff),
      .last_byte (a_last_ff),
      .span      (span)
   );

   // Hold the input byte until the walker takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         a_valid_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         a_byte_ff <= req_ch.data_byte;
         a_last_ff <= req_ch.last_byte;
      end
   end

   // Capture the snapshot on the final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
      end
      if (a_step && a_last_ff) begin
         s_span_ff <= span;
      end
   end

   // Turn the snapshot into the three lengths and the status
   always_comb begin
      o_hdr_in    = '0;
      o_trl_in    = '0;
      o_status_in = mbsf_pkg::ST_NOT_MP4;
      if (!s_span_ff.not_mp4) begin
         o_status_in = s_span_ff.walk_failed ? mbsf_pkg::ST_BAD_SIZE : mbsf_pkg::ST_OK;
         if (s_span_ff.leading_ok) begin
            o_hdr_in = s_span_ff.leading_sum;
         end
         if (!s_span_ff.walk_failed && (s_span_ff.mdat_end <= s_span_ff.total)) begin
            o_trl_in = mbsf_pkg::to_u32(s_span_ff.total - s_span_ff.mdat_end);
         end
      end
      o_pay_in = mbsf_pkg::to_u32(s_span_ff.total) - o_hdr_in - o_trl_in;
   end

   // Hold the result until the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (s_move) begin
         o_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         o_valid_ff <= 1'b0;
      end
      if (s_move) begin
         o_hdr_ff    <= o_hdr_in;
         o_trl_ff    <= o_trl_in;
         o_pay_ff    <= o_pay_in;
         o_status_ff <= o_status_in;
      end
   end

   assign rsp_ch.valid          = o_valid_ff;
   assign rsp_ch.header_length  = o_hdr_ff;
   assign rsp_ch.trailer_length = o_trl_ff;
   assign rsp_ch.payload_length = o_pay_ff;
   assign rsp_ch.status         = o_status_ff;

   `MBSF_ASSERT(a_stall_only_on_last, clock, reset, !req_ch.ready,
      a_valid_ff && a_last_ff && s_valid_ff, "input stalled without a pending final byte")
   `MBSF_ASSERT_NXT(a_snapshot_kept, clock, reset, s_valid_ff && !s_move, s_valid_ff,
      "snapshot dropped before moving to the result register")
   `MBSF_ASSERT(a_not_mp4_zero, clock, reset,
      rsp_ch.valid && (rsp_ch.status == mbsf_pkg::ST_NOT_MP4),
      (rsp_ch.header_length == 32'd0) && (rsp_ch.trailer_length == 32'd0),
      "unrecognised file with non-zero lengths")
   `MBSF_ASSERT(a_bad_size_trl, clock, reset,
      rsp_ch.valid && (rsp_ch.status == mbsf_pkg::ST_BAD_SIZE),
      rsp_ch.trailer_length == 32'd0, "bad box size with non-zero trailer")

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_BYTES = 1600;
   localparam int RANDOM_FILES = 24;

   // One span result as the block reports it at the end of a file
   typedef struct packed {
      logic [31:0]          header_length;
      logic [31:0]          trailer_length;
      logic [31:0]          payload_length;
      mbsf_pkg::status_type status;
   } box_spans_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mbsf_req_if req_bus ();
   mbsf_rsp_if rsp_bus ();

   mp4_box_span_finder_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #4 clock = ~clock;

   // Walk state mirrored from the block
   mbsf_pkg::ofs_type walk_pos;
   logic [63:0]       hdr_shift;
   int unsigned       hdr_count;
   logic [31:0]       body_left;
   bit                in_lead;
   logic [31:0]       lead_total;
   bit                lead_bad;
   mbsf_pkg::ofs_type mdat_end;
   bit                walk_bad;
   bit                not_mp4;
   bit                first_seen;

   box_spans_type pending_spans[$];
   logic [7:0]    file_bytes[$];

   // Run bookkeeping
   int          mismatches = 0;
   int          results_checked = 0;
   int          bytes_sent = 0;
   int          files_sent = 0;
   int          status_seen[3] = '{0, 0, 0};
   int          cycle_count = 0;
   bit          req_idle_on = 1'b0;
   bit          rsp_idle_on = 1'b0;
   int          stall_requests = 0;
   int          stall_cycles = 0;

   logic [31:0] lead_kinds[5] = '{mbsf_pkg::FOURCC_FTYP, mbsf_pkg::FOURCC_MOOV,
                                  mbsf_pkg::FOURCC_FREE, mbsf_pkg::FOURCC_WIDE,
                                  mbsf_pkg::FOURCC_META};

   function automatic void clear_walk();
      walk_pos   = '0;
      hdr_shift  = '0;
      hdr_count  = 0;
      body_left  = '0;
      in_lead    = 1'b1;
      lead_total = '0;
      lead_bad   = 1'b0;
      mdat_end   = '0;
      walk_bad   = 1'b0;
      not_mp4    = 1'b0;
      first_seen = 1'b0;
   endfunction

   // Advance the walk by one byte; return 1 with the spans on the final byte
   function automatic bit walk_byte(input logic [7:0] b, input logic lst,
                                    output box_spans_type spans);
      mbsf_pkg::ofs_type pos;
      mbsf_pkg::ofs_type box_start;
      mbsf_pkg::ofs_type total;
      logic [31:0]       size;
      logic [31:0]       kind;
      logic [31:0]       hdr_len;
      logic [31:0]       trl_len;
      pos = walk_pos;
      spans = '0;
      hdr_len = '0;
      trl_len = '0;
      if (!walk_bad && !not_mp4) begin
         if (body_left != 0) begin
            body_left--;
         end else begin
            hdr_shift = {hdr_shift[55:0], b};
            hdr_count++;
            if (hdr_count == 8) begin
               hdr_count = 0;
               size = hdr_shift[63:32];
               kind = hdr_shift[31:0];
               box_start = pos - mbsf_pkg::ofs_type'(7);
               // first box must announce an mp4 file
               if (!first_seen) begin
                  first_seen = 1'b1;
                  not_mp4 = (kind != mbsf_pkg::FOURCC_FTYP) &&
                            (kind != mbsf_pkg::FOURCC_MOOV);
               end
               if (!not_mp4) begin
                  if (in_lead) begin
                     case (kind)
                        mbsf_pkg::FOURCC_FTYP, mbsf_pkg::FOURCC_MOOV,
                        mbsf_pkg::FOURCC_FREE, mbsf_pkg::FOURCC_WIDE,
                        mbsf_pkg::FOURCC_META: begin
                           if (size <= 32'd8) lead_bad = 1'b1;
                           else lead_total += size;
                        end
                        default: in_lead = 1'b0;
                     endcase
                  end
                  if (kind == mbsf_pkg::FOURCC_MDAT)
                     mdat_end = box_start + mbsf_pkg::ofs_type'(size);
                  if (size <= 32'd8) walk_bad = 1'b1;
                  else body_left = size - 32'd8;
               end
            end
         end
      end
      walk_pos = pos + mbsf_pkg::ofs_type'(1);
      if (!lst) return 1'b0;

      total = walk_pos;
      if (!first_seen || not_mp4) begin
         spans.status = mbsf_pkg::ST_NOT_MP4;
      end else begin
         spans.status = walk_bad ? mbsf_pkg::ST_BAD_SIZE : mbsf_pkg::ST_OK;
         if (!lead_bad && !in_lead) hdr_len = lead_total;
         if (!walk_bad && mdat_end <= total) trl_len = 32'(total - mdat_end);
      end
      spans.header_length  = hdr_len;
      spans.trailer_length = trl_len;
      spans.payload_length = 32'(total) - hdr_len - trl_len;
      clear_walk();
      return 1'b1;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d (0x%08h) got %0d (0x%08h)",
                  $time, name, want, want, got, got);
      end
   endfunction

   // Compare each result transfer with the oldest expected spans
   always @(posedge clock) begin
      box_spans_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_checked++;
         if (pending_spans.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result hdr %0d trl %0d pay %0d status %0d",
                     $time, rsp_bus.header_length, rsp_bus.trailer_length,
                     rsp_bus.payload_length, rsp_bus.status);
         end else begin
            want = pending_spans.pop_front();
            check_field("header_length", want.header_length, rsp_bus.header_length);
            check_field("trailer_length", want.trailer_length, rsp_bus.trailer_length);
            check_field("payload_length", want.payload_length, rsp_bus.payload_length);
            check_field("status", 32'(want.status), 32'(rsp_bus.status));
            status_seen[want.status]++;
         end
      end
   end

   // Guard against a hung handshake
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_spans.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result receiver: random gap after each transfer, plus long hold-offs on request
   initial begin
      int wait_left;
      int stall_left;
      int seen_results;
      int seen_stalls;
      wait_left = 0;
      stall_left = 0;
      seen_results = 0;
      seen_stalls = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (seen_stalls != stall_requests) begin
            seen_stalls = stall_requests;
            stall_left = stall_cycles;
         end
         if (seen_results != results_checked) begin
            seen_results = results_checked;
            wait_left = rsp_idle_on ? $urandom_range(0, 13) : 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Offer one byte and hold it until transferred, then predict
   task automatic send_byte(input logic [7:0] b, input logic lst);
      int            gap;
      box_spans_type spans;
      gap = req_idle_on ? $urandom_range(0, 13) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= lst;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
      if (walk_byte(b, lst, spans)) pending_spans.push_back(spans);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
      file_bytes.delete();
      files_sent++;
   endtask

   task automatic add_word(input logic [31:0] w);
      for (int k = 3; k >= 0; k--) file_bytes.push_back(w[8*k +: 8]);
   endtask

   task automatic add_body(input int n);
      repeat (n) file_bytes.push_back(8'($urandom));
   endtask

   // Complete box: header then size-8 random body bytes
   task automatic add_box(input logic [31:0] kind, input int size);
      add_word(32'(size));
      add_word(kind);
      if (size > 8) add_body(size - 8);
   endtask

   task automatic test_short_files();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      file_bytes.push_back(8'hff);
      send_file();
      file_bytes = {8'h00, 8'h00, 8'h00, 8'h10, 8'h66, 8'h74, 8'h79};
      send_file();
   endtask

   task automatic test_wrong_magic();
      // later bytes only counted, even a valid-looking ftyp
      add_box(mbsf_pkg::FOURCC_FREE, 9);
      add_box(mbsf_pkg::FOURCC_FTYP, 9);
      send_file();
   endtask

   task automatic test_known_layouts();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      add_box(mbsf_pkg::FOURCC_FTYP, 9);
      add_box(mbsf_pkg::FOURCC_FREE, 9);
      add_box(mbsf_pkg::FOURCC_MDAT, 12);
      add_body(3);
      send_file();
      add_box(mbsf_pkg::FOURCC_MOOV, 10);
      add_box(mbsf_pkg::FOURCC_WIDE, 9);
      add_box(mbsf_pkg::FOURCC_META, 9);
      add_box(mbsf_pkg::FOURCC_MDAT, 9);
      add_box(32'h736b_6970, 9);
      add_box(mbsf_pkg::FOURCC_MDAT, 10);
      send_file();
   endtask

   task automatic test_bad_sizes();
      // bad size inside the leading run
      add_word(32'd0);
      add_word(mbsf_pkg::FOURCC_FTYP);
      add_body(2);
      send_file();
      add_box(mbsf_pkg::FOURCC_FTYP, 9);
      add_word(32'd8);
      add_word(mbsf_pkg::FOURCC_META);
      send_file();
      // bad size after the leading run
      add_box(mbsf_pkg::FOURCC_FTYP, 9);
      add_word(32'd1);
      add_word(mbsf_pkg::FOURCC_MDAT);
      add_body(1);
      send_file();
   endtask

   task automatic test_early_end();
      // data ends inside the leading run
      add_box(mbsf_pkg::FOURCC_FTYP, 12);
      send_file();
      // partial trailing header
      add_box(mbsf_pkg::FOURCC_FTYP, 9);
      add_box(mbsf_pkg::FOURCC_MDAT, 9);
      add_body(5);
      send_file();
      // leading box running past the end
      add_word(32'hffff_fff0);
      add_word(mbsf_pkg::FOURCC_FTYP);
      add_body(4);
      send_file();
   endtask

   task automatic test_mdat_past_end();
      add_box(mbsf_pkg::FOURCC_FTYP, 9);
      add_word(32'hffff_ffff);
      add_word(mbsf_pkg::FOURCC_MDAT);
      add_body(2);
      send_file();
      add_box(mbsf_pkg::FOURCC_FTYP, 9);
      add_word(32'h8000_0000);
      add_word(mbsf_pkg::FOURCC_MDAT);
      send_file();
   endtask

   task automatic test_output_stall();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      stall_cycles = 300;
      stall_requests++;
      // final bytes pile up behind a held result
      repeat (8) begin
         file_bytes.push_back(8'($urandom));
         send_file();
      end
      add_box(mbsf_pkg::FOURCC_FTYP, 9);
      add_box(mbsf_pkg::FOURCC_MDAT, 10);
      send_file();
   endtask

   task automatic build_random_file();
      int          shape;
      int          n;
      logic [31:0] kind;
      shape = $urandom_range(0, 19);
      if (shape < 14) begin
         add_box($urandom_range(0, 1) ? mbsf_pkg::FOURCC_FTYP : mbsf_pkg::FOURCC_MOOV,
                 $urandom_range(9, 24));
         n = $urandom_range(0, 3);
         repeat (n) add_box(lead_kinds[$urandom_range(0, 4)], $urandom_range(9, 24));
         n = $urandom_range(0, 3);
         repeat (n) begin
            kind = $urandom_range(0, 1) ? mbsf_pkg::FOURCC_MDAT : 32'($urandom);
            add_box(kind, $urandom_range(9, 28));
         end
         add_body($urandom_range(0, 10));
         // occasional defect at the tail
         case ($urandom_range(0, 9))
            0: begin
               kind = $urandom_range(0, 1) ? mbsf_pkg::FOURCC_MDAT :
                                             lead_kinds[$urandom_range(0, 4)];
               add_word($urandom_range(0, 8));
               add_word(kind);
               add_body($urandom_range(0, 6));
            end
            1: begin
               add_word(32'($urandom) | 32'h100);
               add_word(mbsf_pkg::FOURCC_MDAT);
               add_body($urandom_range(0, 6));
            end
            2: begin
               n = $urandom_range(1, file_bytes.size());
               while (file_bytes.size() > n) void'(file_bytes.pop_back());
            end
            default: ;
         endcase
      end else if (shape < 17) begin
         add_body($urandom_range(1, 20));
      end else begin
         kind = $urandom_range(0, 1) ? lead_kinds[$urandom_range(2, 4)] : 32'($urandom);
         add_box(kind, $urandom_range(9, 16));
         add_body($urandom_range(0, 8));
      end
      if (file_bytes.size() == 0) file_bytes.push_back(8'($urandom));
   endtask

   task automatic test_random_files();
      int byte_goal;
      int file_goal;
      byte_goal = bytes_sent + RANDOM_BYTES;
      file_goal = files_sent + RANDOM_FILES;
      while (bytes_sent < byte_goal || files_sent < file_goal) begin
         req_idle_on = $urandom_range(0, 3) != 0;
         rsp_idle_on = $urandom_range(0, 3) != 0;
         build_random_file();
         send_file();
      end
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.last_byte = 1'b0;
      clear_walk();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_short_files();
      test_wrong_magic();
      test_known_layouts();
      test_bad_sizes();
      test_early_end();
      test_mdat_past_end();
      test_output_stall();
      test_random_files();

      // release the input and drain outstanding results
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_spans.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Walked %0d files in %0d bytes; %0d results: %0d ok, %0d not mp4, %0d bad size",
               files_sent, bytes_sent, results_checked, status_seen[mbsf_pkg::ST_OK],
               status_seen[mbsf_pkg::ST_NOT_MP4], status_seen[mbsf_pkg::ST_BAD_SIZE]);
      if (mismatches == 0 && pending_spans.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d field mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
